// File: hw/rtl/ssq_pkg.sv
package ssq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W        = 8;
  localparam int TIME_W      = 16;
  localparam int KEY_W       = 2 * TIME_W + ID_W;
  localparam int LEN_W       = 5;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic {
    OP_REQUEST = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic {
    CLASS_ECONOMY  = 1'b0,
    CLASS_BUSINESS = 1'b1
  } class_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } row_cmd_t;

endpackage

// File: hw/rtl/ssq_in_if.sv
interface ssq_in_if
  import ssq_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              op;
  logic              queue_class;
  logic [ID_W-1:0]   cust_id;
  logic [TIME_W-1:0] arrival;
  logic [TIME_W-1:0] service;

  modport source (output valid, op, queue_class, cust_id, arrival, service, input ready);
  modport sink   (input valid, op, queue_class, cust_id, arrival, service, output ready);
endinterface

// File: hw/rtl/ssq_out_if.sv
interface ssq_out_if
  import ssq_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             granted;
  logic             head_valid;
  logic [ID_W-1:0]  head_id;
  logic [LEN_W-1:0] length;
  logic [1:0]       status;

  modport source (output valid, granted, head_valid, head_id, length, status, input ready);
  modport sink   (input valid, granted, head_valid, head_id, length, status, output ready);
endinterface

// File: hw/rtl/ssq_cell.sv
module ssq_cell
  import ssq_pkg::*;
(
  input  logic     clk,
  input  row_cmd_t cmd,
  input  key_t     new_key,
  input  key_t     left_key,
  input  key_t     right_key,
  input  logic     occupied,
  input  logic     hold,
  input  logic     stay_in,
  output logic     stay_out,
  output key_t     key_r,
  output key_t     key_nxt
);

  logic here_stays;

  // an occupied entry stays in place if it sorts at or before the new key, or if hold is set
  assign here_stays = occupied && ((key_r <= new_key) || hold);
  assign stay_out   = stay_in && here_stays;

  always_comb begin
    key_nxt = key_r;
    if (cmd.ins) begin
      if (stay_out) begin
        key_nxt = key_r;
      end else if (stay_in) begin
        key_nxt = new_key;
      end else begin
        key_nxt = left_key;
      end
    end else if (cmd.pop) begin
      key_nxt = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

// File: hw/rtl/ssq_row.sv
module ssq_row
  import ssq_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  row_cmd_t        cmd,
  input  key_t            new_key,
  input  logic            server_busy,
  output cnt_t            count_r,
  output logic [ID_W-1:0] head_id_nxt
);

  key_t key_q   [QUEUE_DEPTH];
  key_t key_nxt [QUEUE_DEPTH];
  logic stay    [QUEUE_DEPTH+1];

  assign stay[0] = 1'b1;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    key_t left_key;
    key_t right_key;
    logic occupied;

    if (i == 0) begin : g_first
      assign left_key = new_key;
    end else begin : g_mid_l
      assign left_key = key_q[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_key = key_q[i];
    end else begin : g_mid_r
      assign right_key = key_q[i+1];
    end

    assign occupied = cnt_t'(i) < count_r;

    ssq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .new_key   (new_key),
      .left_key  (left_key),
      .right_key (right_key),
      .occupied  (occupied),
      .hold      ((i == 0) && server_busy),
      .stay_in   (stay[i]),
      .stay_out  (stay[i+1]),
      .key_r     (key_q[i]),
      .key_nxt   (key_nxt[i])
    );
  end

  assign head_id_nxt = key_nxt[0][ID_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.ins) begin
      count_r <= count_r + cnt_t'(1);
    end else if (cmd.pop) begin
      count_r <= count_r - cnt_t'(1);
    end
  end

endmodule

// File: hw/rtl/sorted_service_queue.sv
// sorted_service_queue: two sorted waiting queues (economy, business) that
// share one server flag.
// in_ch carries one command per transfer: a request inserts a customer into
// the queue of its class, ordered by arrival, then service, then id; a
// release pops the head of its class queue and passes the server on.
// out_ch returns one result per command: grant, head state, length, status.
// Each queue is a row of cells, one entry each, updated at once: a pop
// moves every cell from its neighbor, an insert those behind the new key.
// A transferred command waits in the command register, then executes when
// the output register is free or being read: the cells update and the
// result is registered. One command is pending at a time, so a new command
// is taken only after the pending one has executed.
// Reset (synchronous, rst_n low) empties both queues, frees the server and
// drops any pending command and result. Queue contents need no clearing.
// When the receiver stalls, the result is held in the output register and
// one further command may be taken; it then waits until the result leaves.
module sorted_service_queue
  import ssq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  ssq_in_if.sink    in_ch,
  ssq_out_if.source out_ch
);

  logic              pend_r;
  logic              op_r;
  logic              class_r;
  key_t              key_r;
  logic              server_busy_r;
  logic              server_busy_nxt;

  logic              out_valid_r;
  logic              granted_r;
  logic              head_valid_r;
  logic [ID_W-1:0]   head_id_r;
  logic [LEN_W-1:0]  length_r;
  status_t           status_r;

  logic              exec;
  cnt_t              cnt_e;
  cnt_t              cnt_b;
  cnt_t              cnt;
  cnt_t              cnt_after;
  logic              full;
  logic              empty;
  logic              do_ins;
  logic              do_pop;
  logic              granted;
  status_t           status;
  row_cmd_t          cmd_e;
  row_cmd_t          cmd_b;
  logic [ID_W-1:0]   head_e;
  logic [ID_W-1:0]   head_b;
  logic [ID_W-1:0]   head_sel;

  assign in_ch.ready = !pend_r;
  assign exec        = pend_r && (!out_valid_r || out_ch.ready);

  assign cnt    = (class_r == CLASS_BUSINESS) ? cnt_b : cnt_e;
  assign full   = cnt == cnt_t'(QUEUE_DEPTH);
  assign empty  = cnt == '0;
  assign do_ins = exec && (op_r == OP_REQUEST) && !full;
  assign do_pop = exec && (op_r == OP_RELEASE) && !empty;

  assign cmd_e = '{ins: do_ins && (class_r == CLASS_ECONOMY),
                   pop: do_pop && (class_r == CLASS_ECONOMY)};
  assign cmd_b = '{ins: do_ins && (class_r == CLASS_BUSINESS),
                   pop: do_pop && (class_r == CLASS_BUSINESS)};

  always_comb begin
    cnt_after       = cnt;
    server_busy_nxt = server_busy_r;
    granted         = 1'b0;
    status          = ST_OK;
    if (op_r == OP_REQUEST) begin
      if (full) begin
        status = ST_FULL;
      end else begin
        cnt_after       = cnt + cnt_t'(1);
        server_busy_nxt = 1'b1;
        granted         = !server_busy_r;
      end
    end else begin
      if (empty) begin
        status = ST_EMPTY;
      end else begin
        cnt_after       = cnt - cnt_t'(1);
        server_busy_nxt = cnt_after != '0;
        granted         = cnt_after != '0;
      end
    end
  end

  assign head_sel = (class_r == CLASS_BUSINESS) ? head_b : head_e;

  ssq_row u_row_e (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd_e),
    .new_key     (key_r),
    .server_busy (server_busy_r),
    .count_r     (cnt_e),
    .head_id_nxt (head_e)
  );

  ssq_row u_row_b (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd_b),
    .new_key     (key_r),
    .server_busy (server_busy_r),
    .count_r     (cnt_b),
    .head_id_nxt (head_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r        <= 1'b0;
      server_busy_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        pend_r <= 1'b1;
      end else if (exec) begin
        pend_r <= 1'b0;
      end
      if (exec) begin
        server_busy_r <= server_busy_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r   <= 1'b0;
      end
    end
  end

  // command capture
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op_r    <= in_ch.op;
      class_r <= in_ch.queue_class;
      key_r   <= {in_ch.arrival, in_ch.service, in_ch.cust_id};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (exec) begin
      granted_r    <= granted;
      head_valid_r <= cnt_after != '0;
      head_id_r    <= (cnt_after != '0) ? head_sel : '0;
      length_r     <= LEN_W'(cnt_after);
      status_r     <= status;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.granted    = granted_r;
  assign out_ch.head_valid = head_valid_r;
  assign out_ch.head_id    = head_id_r;
  assign out_ch.length     = length_r;
  assign out_ch.status     = status_r;

endmodule

// File: hw/rtl/ssq_chk.sv
module ssq_chk
  import ssq_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_granted,
  input logic             out_head_valid,
  input logic [ID_W-1:0]  out_head_id,
  input logic [LEN_W-1:0] out_length,
  input logic [1:0]       out_status
);

  // one command in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second command taken while one is pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_head_id) && $stable(out_status))
    else $error("stalled result changed");

  a_head_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_head_valid == (out_length != '0)) &&
                  (out_head_valid || (out_head_id == '0)))
    else $error("head state disagrees with length");

  a_no_grant_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL || out_status == ST_EMPTY) |-> !out_granted)
    else $error("grant reported with error status");

  a_empty_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |-> (out_length == '0) && !out_head_valid)
    else $error("empty release reported a non-empty queue");

endmodule

bind sorted_service_queue ssq_chk u_ssq_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_granted    (out_ch.granted),
  .out_head_valid (out_ch.head_valid),
  .out_head_id    (out_ch.head_id),
  .out_length     (out_ch.length),
  .out_status     (out_ch.status)
);

// File: bench/ssq_checker.sv
module ssq_checker
  import ssq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  ssq_in_if    in_ch,
  ssq_out_if   out_ch,
  output int   mismatches,
  output int   outstanding
);

  typedef struct {
    logic             granted;
    logic             head_valid;
    logic [ID_W-1:0]  head_id;
    logic [LEN_W-1:0] length;
    logic [1:0]       status;
  } svc_result_t;

  key_t        line_q [2][QUEUE_DEPTH];
  int          line_n [2];
  bit          server_taken;
  svc_result_t pending_results[$];

  function automatic svc_result_t serve_cmd(op_t op, class_t cls, key_t key);
    svc_result_t r;
    int c;
    int n;
    int pos;
    int i;
    c = int'(cls);
    n = line_n[c];
    r.granted = 1'b0;
    r.status  = ST_OK;
    if (op == OP_REQUEST) begin
      if (n >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // head stays put while the server is held
        pos = (server_taken && n > 0) ? 1 : 0;
        while (pos < n && line_q[c][pos] <= key) pos++;
        for (i = n; i > pos; i--) line_q[c][i] = line_q[c][i-1];
        line_q[c][pos] = key;
        line_n[c] = n + 1;
        if (!server_taken) begin
          server_taken = 1'b1;
          r.granted    = 1'b1;
        end
      end
    end else begin
      if (n == 0) begin
        r.status = ST_EMPTY;
      end else begin
        for (i = 0; i + 1 < n; i++) line_q[c][i] = line_q[c][i+1];
        line_n[c]    = n - 1;
        server_taken = 1'b0;
        if (line_n[c] > 0) begin
          server_taken = 1'b1;
          r.granted    = 1'b1;
        end
      end
    end
    r.head_valid = (line_n[c] > 0);
    r.head_id    = (line_n[c] > 0) ? line_q[c][0][ID_W-1:0] : '0;
    r.length     = LEN_W'(line_n[c]);
    return r;
  endfunction

  always @(posedge clk) begin
    svc_result_t want;
    if (!rst_n) begin
      pending_results.delete();
      line_n[0]    = 0;
      line_n[1]    = 0;
      server_taken = 1'b0;
      outstanding <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with no command outstanding");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (out_ch.granted !== want.granted) begin
            $error("granted: expected %0d, got %0d", want.granted, out_ch.granted);
            mismatches++;
          end
          if (out_ch.head_valid !== want.head_valid) begin
            $error("head_valid: expected %0d, got %0d", want.head_valid, out_ch.head_valid);
            mismatches++;
          end
          if (out_ch.head_id !== want.head_id) begin
            $error("head_id: expected %0d, got %0d", want.head_id, out_ch.head_id);
            mismatches++;
          end
          if (out_ch.length !== want.length) begin
            $error("length: expected %0d, got %0d", want.length, out_ch.length);
            mismatches++;
          end
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            mismatches++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        pending_results.push_back(serve_cmd(op_t'(in_ch.op), class_t'(in_ch.queue_class),
                                            {in_ch.arrival, in_ch.service, in_ch.cust_id}));
      end
      outstanding <= pending_results.size();
    end
  end

endmodule

// File: bench/tb_sorted_service_queue.sv
module tb_sorted_service_queue;
  import ssq_pkg::*;

  logic clk = 1'b0;
  logic rst_n;
  int   mismatches;
  int   outstanding;
  int   burst_left;

  ssq_in_if  cmd_ch ();
  ssq_out_if res_ch ();

  sorted_service_queue uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cmd_ch),
    .out_ch (res_ch)
  );

  ssq_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (cmd_ch),
    .out_ch      (res_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(0, 3))
      0, 1:    return TIME_W'($urandom_range(0, 7));
      2:       return TIME_W'($urandom);
      default: return ($urandom_range(0, 1) != 0) ? '1 : '0;
    endcase
  endfunction

  task automatic issue(input op_t op, input class_t cls, input logic [ID_W-1:0] id,
                       input logic [TIME_W-1:0] arr, input logic [TIME_W-1:0] svc);
    cmd_ch.valid       <= 1'b1;
    cmd_ch.op          <= op;
    cmd_ch.queue_class <= cls;
    cmd_ch.cust_id     <= id;
    cmd_ch.arrival     <= arr;
    cmd_ch.service     <= svc;
    do @(posedge clk); while (!cmd_ch.ready);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  // receiver stalls in modes of random length
  initial begin
    int mode;
    res_ch.ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(20, 80)) begin
        @(posedge clk);
        case (mode)
          0:       res_ch.ready <= 1'b1;
          1:       res_ch.ready <= ($urandom_range(0, 1) != 0);
          2:       res_ch.ready <= ($urandom_range(0, 3) == 0);
          default: res_ch.ready <= ($urandom_range(0, 11) == 0);
        endcase
      end
    end
  end

  initial begin
    int     k;
    int     phase_left;
    int     req_pct;
    class_t fav;
    op_t    op;
    class_t cls;
    rst_n              <= 1'b0;
    cmd_ch.valid       <= 1'b0;
    cmd_ch.op          <= OP_REQUEST;
    cmd_ch.queue_class <= CLASS_ECONOMY;
    cmd_ch.cust_id     <= '0;
    cmd_ch.arrival     <= '0;
    cmd_ch.service     <= '0;
    burst_left = $urandom_range(1, 24);
    phase_left = 0;
    req_pct    = 50;
    fav        = CLASS_ECONOMY;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queues, grant on first request, busy insert into empty queue, ties
    issue(OP_RELEASE, CLASS_ECONOMY, 8'h00, 16'h0000, 16'h0000);
    issue(OP_RELEASE, CLASS_BUSINESS, 8'hFF, 16'hFFFF, 16'hFFFF);
    issue(OP_REQUEST, CLASS_BUSINESS, 8'hFF, 16'hFFFF, 16'hFFFF);
    issue(OP_REQUEST, CLASS_ECONOMY, 8'h00, 16'h0000, 16'h0000);
    issue(OP_REQUEST, CLASS_ECONOMY, 8'h00, 16'h0000, 16'h0000);
    // fill business to the top, smaller keys stay behind the held head
    for (k = 0; k < 15; k++) begin
      case (k % 4)
        0:       issue(OP_REQUEST, CLASS_BUSINESS, ID_W'(k), 16'h0000, 16'hFFFF);
        1:       issue(OP_REQUEST, CLASS_BUSINESS, ID_W'(8'hFF - k), 16'hFFFF, 16'h0000);
        2:       issue(OP_REQUEST, CLASS_BUSINESS, ID_W'(k), 16'h8000, 16'h7FFF);
        default: issue(OP_REQUEST, CLASS_BUSINESS, 8'h80, 16'h7FFF, 16'h8000);
      endcase
    end
    issue(OP_REQUEST, CLASS_BUSINESS, 8'h55, 16'h0001, 16'h0001);
    // pop economy dry, then release business with the server free
    issue(OP_RELEASE, CLASS_ECONOMY, 8'hAA, 16'h5555, 16'hAAAA);
    issue(OP_RELEASE, CLASS_ECONOMY, 8'h00, 16'h0000, 16'h0000);
    issue(OP_RELEASE, CLASS_ECONOMY, 8'h00, 16'h0000, 16'h0000);
    issue(OP_RELEASE, CLASS_BUSINESS, 8'h00, 16'h0000, 16'h0000);

    for (k = 0; k < 1450; k++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 60);
        case ($urandom_range(0, 3))
          0:       req_pct = 85;
          1:       req_pct = 20;
          2:       req_pct = 50;
          default: req_pct = 100 * ($urandom_range(0, 1));
        endcase
        fav = class_t'($urandom_range(0, 1));
      end
      phase_left--;
      op  = ($urandom_range(0, 99) < req_pct) ? OP_REQUEST : OP_RELEASE;
      cls = ($urandom_range(0, 99) < 80) ? fav : class_t'($urandom_range(0, 1));
      issue(op, cls, ID_W'($urandom_range(0, 255)), pick_time(), pick_time());
    end

    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
